@@ hw/rtl/tsd_pkg.sv @@
package tsd_pkg;

	// One character of the timestamp text
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} tsd_char_t;

	// One converted timestamp
	typedef struct packed {
		logic [15:0] dos_date;
		logic [15:0] dos_time;
		logic [1:0]  status;
	} tsd_result_t;

	// Accumulated fields of a finished timestamp, parser to packer
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic        bad;
	} tsd_fields_t;

	// Status codes
	localparam logic [1:0] StatusOk      = 2'd0;
	localparam logic [1:0] StatusBad     = 2'd1;
	localparam logic [1:0] StatusIgnored = 2'd2;

	// Character positions of the separators and the last character
	localparam logic [4:0] PosDash1   = 5'd4;
	localparam logic [4:0] PosDash2   = 5'd7;
	localparam logic [4:0] PosT       = 5'd10;
	localparam logic [4:0] PosColon1  = 5'd13;
	localparam logic [4:0] PosColon2  = 5'd16;
	localparam logic [4:0] PosLast    = 5'd18;
	localparam logic [4:0] TsLen      = 5'd19;
	localparam logic [4:0] PosMax     = 5'd31;

	// ASCII codes
	localparam logic [7:0] ChDash  = 8'h2D;
	localparam logic [7:0] ChT     = 8'h54;
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	// Field limits
	localparam logic [13:0] YearMin    = 14'd1900;
	localparam logic [13:0] DosYearMin = 14'd1980;
	localparam logic [13:0] DosYearMax = 14'd2107;
	localparam logic [6:0]  MonthMax   = 7'd12;
	localparam logic [6:0]  DayMax     = 7'd31;
	localparam logic [6:0]  HourMax    = 7'd23;
	localparam logic [6:0]  MinSecMax  = 7'd59;

endpackage

@@ hw/rtl/iso_timestamp_to_dos_datetime.sv @@
// Converts YYYY-MM-DDThh:mm:ss text, one character per transfer, to MS-DOS date/time.
// Throughput: one character per cycle while the result side does not stall; the decimal accumulate is combinational.
// Pipeline: two register stages; the parser output register loads at the transfer of the
// last character, and the result then passes to the pack/output register once it is free.
// Reset (arst_n low, asynchronous) clears the character position, accumulators,
// error flag and both valid bits; no result is pending after reset.
module iso_timestamp_to_dos_datetime (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  tsd_pkg::tsd_char_t   char_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output tsd_pkg::tsd_result_t result_data
);

	logic                 fields_valid;
	logic                 fields_ready;
	tsd_pkg::tsd_fields_t fields;

	// Character parser and field accumulators
	tsd_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_data    (char_data),
		.fields_valid (fields_valid),
		.fields_ready (fields_ready),
		.fields       (fields)
	);

	// Range check and word packing
	tsd_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.fields_valid (fields_valid),
		.fields_ready (fields_ready),
		.fields       (fields),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

@@ hw/rtl/tsd_parse.sv @@
module tsd_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  tsd_pkg::tsd_char_t   char_data,
	output logic                 fields_valid,
	input  logic                 fields_ready,
	output tsd_pkg::tsd_fields_t fields
);

	// Decimal accumulate, truncated to the field width
	function automatic logic [13:0] dec14(input logic [13:0] a, input logic [3:0] d);
		logic [17:0] w;
		w = 18'(a) * 18'd10 + 18'(d);
		return w[13:0];
	endfunction

	function automatic logic [6:0] dec7(input logic [6:0] a, input logic [3:0] d);
		logic [10:0] w;
		w = 11'(a) * 11'd10 + 11'(d);
		return w[6:0];
	endfunction

	logic [4:0]  pos_q;
	logic [13:0] year_q,   year_nxt;
	logic [6:0]  month_q,  month_nxt;
	logic [6:0]  day_q,    day_nxt;
	logic [6:0]  hour_q,   hour_nxt;
	logic [6:0]  minute_q, minute_nxt;
	logic [6:0]  second_q, second_nxt;
	logic        bad_q,    bad_nxt;
	logic        is_digit;
	logic [3:0]  digit;
	logic        accept;
	logic        fields_valid_s1;
	tsd_pkg::tsd_fields_t fields_s1;

	assign char_ready   = !fields_valid_s1 || fields_ready;
	assign accept       = char_valid && char_ready;
	assign fields_valid = fields_valid_s1;
	assign fields       = fields_s1;

	assign is_digit = (char_data.char_code >= tsd_pkg::ChZero) &&
	                  (char_data.char_code <= tsd_pkg::ChNine);
	assign digit    = char_data.char_code[3:0];

	// Per-character check and accumulate
	always_comb begin
		year_nxt   = year_q;
		month_nxt  = month_q;
		day_nxt    = day_q;
		hour_nxt   = hour_q;
		minute_nxt = minute_q;
		second_nxt = second_q;
		bad_nxt    = bad_q;
		if (pos_q >= tsd_pkg::TsLen) begin
			bad_nxt = 1'b1;
		end else if (pos_q inside {tsd_pkg::PosDash1, tsd_pkg::PosDash2}) begin
			if (char_data.char_code != tsd_pkg::ChDash) bad_nxt = 1'b1;
		end else if (pos_q == tsd_pkg::PosT) begin
			if (char_data.char_code != tsd_pkg::ChT) bad_nxt = 1'b1;
		end else if (pos_q inside {tsd_pkg::PosColon1, tsd_pkg::PosColon2}) begin
			if (char_data.char_code != tsd_pkg::ChColon) bad_nxt = 1'b1;
		end else if (!is_digit) begin
			bad_nxt = 1'b1;
		end else if (pos_q < tsd_pkg::PosDash1) begin
			year_nxt = dec14(year_q, digit);
		end else if (pos_q < tsd_pkg::PosDash2) begin
			month_nxt = dec7(month_q, digit);
		end else if (pos_q < tsd_pkg::PosT) begin
			day_nxt = dec7(day_q, digit);
		end else if (pos_q < tsd_pkg::PosColon1) begin
			hour_nxt = dec7(hour_q, digit);
		end else if (pos_q < tsd_pkg::PosColon2) begin
			minute_nxt = dec7(minute_q, digit);
		end else begin
			second_nxt = dec7(second_q, digit);
		end
	end

	// Parser state; cleared after the last character of each timestamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			bad_q    <= 1'b0;
		end else if (accept) begin
			if (char_data.is_last) begin
				pos_q    <= '0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				bad_q    <= 1'b0;
			end else begin
				if (pos_q != tsd_pkg::PosMax) pos_q <= pos_q + 5'd1;
				year_q   <= year_nxt;
				month_q  <= month_nxt;
				day_q    <= day_nxt;
				hour_q   <= hour_nxt;
				minute_q <= minute_nxt;
				second_q <= second_nxt;
				bad_q    <= bad_nxt;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_valid_s1 <= 1'b0;
		end else if (accept && char_data.is_last) begin
			fields_valid_s1 <= 1'b1;
		end else if (fields_ready) begin
			fields_valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload: final fields of the timestamp
	always_ff @(posedge clk) begin
		if (accept && char_data.is_last) begin
			fields_s1.year   <= year_nxt;
			fields_s1.month  <= month_nxt;
			fields_s1.day    <= day_nxt;
			fields_s1.hour   <= hour_nxt;
			fields_s1.minute <= minute_nxt;
			fields_s1.second <= second_nxt;
			fields_s1.bad    <= bad_nxt || (pos_q != tsd_pkg::PosLast);
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && char_data.is_last |=> pos_q == '0 && !bad_q && year_q == '0)
		else $error("parser state not cleared after last character");

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !char_data.is_last && pos_q == tsd_pkg::PosMax |=>
		pos_q == tsd_pkg::PosMax && bad_q)
		else $error("character position did not saturate");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fields_valid_s1 && !fields_ready |=> fields_valid_s1 && $stable(fields_s1))
		else $error("stage 1 fields lost under backpressure");
`endif

endmodule

@@ hw/rtl/tsd_pack.sv @@
module tsd_pack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fields_valid,
	output logic                 fields_ready,
	input  tsd_pkg::tsd_fields_t fields,
	output logic                 result_valid,
	input  logic                 result_ready,
	output tsd_pkg::tsd_result_t result_data
);

	logic                bad;
	logic                in_dos_range;
	logic [13:0]         year_off;
	logic                result_valid_q;
	tsd_pkg::tsd_result_t result_nxt;
	tsd_pkg::tsd_result_t result_q;

	assign fields_ready = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// Range checks
	assign bad = fields.bad ||
	             (fields.year < tsd_pkg::YearMin) ||
	             (fields.month == '0) || (fields.month > tsd_pkg::MonthMax) ||
	             (fields.day == '0) || (fields.day > tsd_pkg::DayMax) ||
	             (fields.hour > tsd_pkg::HourMax) ||
	             (fields.minute > tsd_pkg::MinSecMax) ||
	             (fields.second > tsd_pkg::MinSecMax);
	assign in_dos_range = (fields.year >= tsd_pkg::DosYearMin) &&
	                      (fields.year <= tsd_pkg::DosYearMax);
	assign year_off     = fields.year - tsd_pkg::DosYearMin;

	// Pack the date and time words
	always_comb begin
		result_nxt.dos_date = '0;
		result_nxt.dos_time = '0;
		if (bad) begin
			result_nxt.status = tsd_pkg::StatusBad;
		end else if (!in_dos_range) begin
			result_nxt.status = tsd_pkg::StatusIgnored;
		end else begin
			result_nxt.status   = tsd_pkg::StatusOk;
			result_nxt.dos_date = {year_off[6:0], fields.month[3:0], fields.day[4:0]};
			result_nxt.dos_time = {fields.hour[4:0], fields.minute[5:0], fields.second[5:1]};
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fields_valid && fields_ready) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (fields_valid && fields_ready) result_q <= result_nxt;
	end

`ifndef SYNTHESIS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> result_q.status == tsd_pkg::StatusOk ||
		result_q.status == tsd_pkg::StatusBad ||
		result_q.status == tsd_pkg::StatusIgnored)
		else $error("undefined status code");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status != tsd_pkg::StatusOk |->
		result_q.dos_date == '0 && result_q.dos_time == '0)
		else $error("nonzero words with failing status");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status == tsd_pkg::StatusOk |->
		result_q.dos_date[4:0] != '0 && result_q.dos_date[8:5] != '0 &&
		result_q.dos_time[15:11] <= 5'd23)
		else $error("packed fields out of range with ok status");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int     ClkHalf     = 10;
	localparam int     RandomChars = 1500;
	localparam longint TimeoutNs   = 10_000_000;

	typedef enum int {RxSteady, RxRandom, RxPeriodic} rx_mode_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 char_valid   = 1'b0;
	logic                 char_ready;
	tsd_pkg::tsd_char_t   char_data    = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	tsd_pkg::tsd_result_t result_data;

	iso_timestamp_to_dos_datetime u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_data    (char_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	// Parser state mirrored on the testbench side
	logic [4:0]  pos_q     = '0;
	logic [13:0] year_q    = '0;
	logic [6:0]  month_q   = '0;
	logic [6:0]  day_q     = '0;
	logic [6:0]  hour_q    = '0;
	logic [6:0]  minute_q  = '0;
	logic [6:0]  second_q  = '0;
	logic        fmt_bad_q = 1'b0;

	tsd_pkg::tsd_result_t pending_dos_words[$];

	int error_count   = 0;
	int chars_sent    = 0;
	int results_seen  = 0;
	int stall_cycles  = 0;
	int status_count[3];
	bit tx_calm       = 1'b0;
	int burst_left    = 0;
	int rx_hold_req   = 0;

	initial begin
		forever #ClkHalf clk = ~clk;
	end

	initial begin
		#(TimeoutNs);
		$display("timeout with %0d timestamps still outstanding", pending_dos_words.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	// Advance the parser by one character; on the last one, queue the DOS words
	task automatic convert_char(input tsd_pkg::tsd_char_t c);
		logic                 digit;
		logic [3:0]           d;
		logic                 wrong;
		tsd_pkg::tsd_result_t r;
		digit = (c.char_code >= tsd_pkg::ChZero) && (c.char_code <= tsd_pkg::ChNine);
		d = c.char_code[3:0];
		if (pos_q >= tsd_pkg::TsLen) begin
			fmt_bad_q = 1'b1;
		end else if (pos_q == tsd_pkg::PosDash1 || pos_q == tsd_pkg::PosDash2) begin
			if (c.char_code != tsd_pkg::ChDash) fmt_bad_q = 1'b1;
		end else if (pos_q == tsd_pkg::PosT) begin
			if (c.char_code != tsd_pkg::ChT) fmt_bad_q = 1'b1;
		end else if (pos_q == tsd_pkg::PosColon1 || pos_q == tsd_pkg::PosColon2) begin
			if (c.char_code != tsd_pkg::ChColon) fmt_bad_q = 1'b1;
		end else if (!digit) begin
			fmt_bad_q = 1'b1;
		end else if (pos_q < tsd_pkg::PosDash1) begin
			year_q = year_q * 14'd10 + 14'(d);
		end else if (pos_q < tsd_pkg::PosDash2) begin
			month_q = month_q * 7'd10 + 7'(d);
		end else if (pos_q < tsd_pkg::PosT) begin
			day_q = day_q * 7'd10 + 7'(d);
		end else if (pos_q < tsd_pkg::PosColon1) begin
			hour_q = hour_q * 7'd10 + 7'(d);
		end else if (pos_q < tsd_pkg::PosColon2) begin
			minute_q = minute_q * 7'd10 + 7'(d);
		end else begin
			second_q = second_q * 7'd10 + 7'(d);
		end

		if (!c.is_last) begin
			// position saturates so overlong text stays flagged
			if (pos_q < tsd_pkg::PosMax) pos_q++;
		end else begin
			wrong = fmt_bad_q || (pos_q != tsd_pkg::PosLast) || (year_q < tsd_pkg::YearMin)
				|| (month_q < 7'd1) || (month_q > tsd_pkg::MonthMax)
				|| (day_q < 7'd1) || (day_q > tsd_pkg::DayMax)
				|| (hour_q > tsd_pkg::HourMax) || (minute_q > tsd_pkg::MinSecMax)
				|| (second_q > tsd_pkg::MinSecMax);
			r = '0;
			if (wrong) begin
				r.status = tsd_pkg::StatusBad;
			end else if (year_q < tsd_pkg::DosYearMin || year_q > tsd_pkg::DosYearMax) begin
				r.status = tsd_pkg::StatusIgnored;
			end else begin
				r.status   = tsd_pkg::StatusOk;
				r.dos_date = {7'(year_q - tsd_pkg::DosYearMin), month_q[3:0], day_q[4:0]};
				r.dos_time = {hour_q[4:0], minute_q[5:0], second_q[5:1]};
			end
			pending_dos_words.push_back(r);
			status_count[r.status]++;
			// back to the start of a new timestamp
			pos_q     = '0;
			year_q    = '0;
			month_q   = '0;
			day_q     = '0;
			hour_q    = '0;
			minute_q  = '0;
			second_q  = '0;
			fmt_bad_q = 1'b0;
		end
	endtask

	// One character transfer, then maybe a gap before the next burst
	task automatic send_char(input logic [7:0] code, input logic last);
		tsd_pkg::tsd_char_t c;
		int                 gap;
		c.char_code = code;
		c.is_last   = last;
		char_data  <= c;
		char_valid <= 1'b1;
		do @(posedge clk); while (!char_ready);
		chars_sent++;
		convert_char(c);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = tx_calm ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++) begin
			send_char(text[i], i == text.len() - 1);
		end
	endtask

	// Drop valid and let every queued conversion come out
	task automatic wait_all_results();
		char_valid <= 1'b0;
		@(posedge clk);
		while (pending_dos_words.size() != 0) @(posedge clk);
	endtask

	task automatic check_result(input tsd_pkg::tsd_result_t got);
		tsd_pkg::tsd_result_t want;
		if (pending_dos_words.size() == 0) begin
			report_mismatch($sformatf("result %h with nothing pending", got));
		end else begin
			want = pending_dos_words.pop_front();
			results_seen++;
			if (got.dos_date !== want.dos_date) begin
				report_mismatch($sformatf("result %0d dos_date %h, want %h",
					results_seen, got.dos_date, want.dos_date));
			end
			if (got.dos_time !== want.dos_time) begin
				report_mismatch($sformatf("result %0d dos_time %h, want %h",
					results_seen, got.dos_time, want.dos_time));
			end
			if (got.status !== want.status) begin
				report_mismatch($sformatf("result %0d status %0d, want %0d",
					results_seen, got.status, want.status));
			end
		end
	endtask

	// Result side: check each transfer and drive ready on a changing pattern
	initial begin : result_sink
		int       hold_left;
		int       mode_left;
		int       cyc;
		rx_mode_t mode;
		hold_left = 0;
		mode_left = 0;
		cyc       = 0;
		mode      = RxSteady;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) check_result(result_data);
			if (arst_n && char_valid && !char_ready) stall_cycles++;
			if (rx_hold_req > 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				case (mode)
					RxSteady: begin
						result_ready <= 1'b1;
					end
					RxRandom: begin
						result_ready <= ($urandom_range(0, 1) == 1);
					end
					default: begin
						result_ready <= (cyc % 5 > 1);
					end
				endcase
			end
		end
	end

	// Well-formed text; each field now and then out of range
	function automatic string random_timestamp();
		int yr, mo, dy, hr, mi, se;
		yr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999) : $urandom_range(1890, 2120);
		mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
		dy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
		hr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
		mi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
		se = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
		return $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", yr, mo, dy, hr, mi, se);
	endfunction

	// Field extremes, year window edges, odd seconds, day not checked against month
	task automatic test_valid_extremes();
		send_text("1980-01-01T00:00:00");
		send_text("2107-12-31T23:59:59");
		send_text("2024-02-31T13:37:01");
		send_text("1979-12-31T23:59:58");
		send_text("2108-01-01T00:00:00");
		send_text("1900-06-15T08:00:00");
		send_text("1899-12-31T23:59:59");
		wait_all_results();
	endtask

	// Range errors, bad separators, non-digits, wrong lengths, raw byte extremes
	task automatic test_format_errors();
		send_text("2000-00-10T10:10:10");
		send_text("2000-01-32T24:60:60");
		send_text("2000/01-01T00:00:00");
		send_text("2000-01-01 00:00:00");
		send_text("20x0-01-01T00:00:00");
		send_text("2000-01-01T00:00:0");
		send_text("2000-01-01T00:00:000");
		send_text("T");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		wait_all_results();
	endtask

	// Hold results off for a long time while characters keep coming
	task automatic test_output_backpressure();
		tx_calm     = 1'b1;
		rx_hold_req = 400;
		repeat (12) begin
			send_text(random_timestamp());
			send_char("x", 1'b1);
			send_char("9", 1'b1);
		end
		wait_all_results();
		tx_calm = 1'b0;
	endtask

	// Mostly well-formed timestamps, the rest broken text and raw noise
	task automatic test_random_stream();
		int    start_count;
		int    pick;
		int    n;
		string s;
		string seps;
		start_count = chars_sent;
		seps = "-T: /";
		while (chars_sent - start_count < RandomChars) begin
			if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				n = $urandom_range(1, 40);
				for (int i = 0; i < n; i++) begin
					send_char(8'($urandom_range(0, 255)), i == n - 1);
				end
			end else begin
				s = random_timestamp();
				if (pick < 70) begin
					// clean text
				end else if (pick < 78) begin
					s[$urandom_range(0, 18)] = 8'($urandom_range(1, 255));
				end else if (pick < 86) begin
					s = s.substr(0, $urandom_range(0, 17));
				end else if (pick < 94) begin
					// overlong, some past the position saturation
					repeat ($urandom_range(1, 16)) s = {s, $sformatf("%c", $urandom_range(48, 57))};
				end else begin
					s[$urandom_range(0, 4) * 3 + 4] = seps[$urandom_range(0, 4)];
				end
				send_text(s);
			end
		end
		wait_all_results();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_valid_extremes();
		test_format_errors();
		test_output_backpressure();
		test_random_stream();

		// catch any stray result after the last one
		repeat (10) @(posedge clk);
		$display("sent %0d characters, checked %0d timestamps: %0d packed, %0d rejected, %0d %s",
			chars_sent, results_seen, status_count[tsd_pkg::StatusOk],
			status_count[tsd_pkg::StatusBad], status_count[tsd_pkg::StatusIgnored],
			"out of DOS range");
		$display("character input was held off for %0d cycles by result backpressure", stall_cycles);
		if (error_count == 0 && pending_dos_words.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
